// ----- src/mbrc_pkg.sv -----
// Types, codes and the CRC-16/MODBUS byte update for the Modbus RTU response checker.
// No dependencies; used by every other file of the block except mbrc_if.
`timescale 1ns / 1ps
`default_nettype none

package mbrc_pkg;

  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;  // byte counter saturates here

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;  // reflected 0x8005

  // request kinds
  localparam logic [2:0] KIND_RD_COILS = 3'd0;
  localparam logic [2:0] KIND_RD_HOLD  = 3'd1;
  localparam logic [2:0] KIND_RD_INPUT = 3'd2;
  localparam logic [2:0] KIND_WR_SINGLE = 3'd3;
  localparam logic [2:0] KIND_WR_MULTI = 3'd4;

  // function codes
  localparam logic [7:0] FC_NONE      = 8'h00;
  localparam logic [7:0] FC_RD_COILS  = 8'h01;
  localparam logic [7:0] FC_RD_HOLD   = 8'h03;
  localparam logic [7:0] FC_RD_INPUT  = 8'h04;
  localparam logic [7:0] FC_WR_SINGLE = 8'h06;
  localparam logic [7:0] FC_WR_MULTI  = 8'h10;
  localparam logic [7:0] FC_EXC_FLAG  = 8'h80;

  localparam logic [POS_W-1:0] MIN_FRAME   = 9'd5;  // slave, fc, one byte, crc
  localparam logic [POS_W-1:0] WRITE_FRAME = 9'd8;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_ZERO_QTY   = 4'd1,
    ST_SHORT      = 4'd2,
    ST_SLAVE      = 4'd3,
    ST_EXC_LEN    = 4'd4,
    ST_EXC_CRC    = 4'd5,
    ST_EXCEPTION  = 4'd6,
    ST_FUNCTION   = 4'd7,
    ST_LENGTH     = 4'd8,
    ST_CRC        = 4'd9,
    ST_BYTE_COUNT = 4'd10,
    ST_ADDRESS    = 4'd11,
    ST_VALUE      = 4'd12
  } status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  slave;
    logic [15:0] address;
    logic [15:0] qty_word;
  } req_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
    req_t       req;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic       is_status;
    logic [7:0] data_byte;
    status_e    status;
    logic [7:0] exception_code;
  } result_t;

  function automatic logic [7:0] fc_of_kind(input logic [2:0] kind);
    logic [7:0] fc;
    case (kind)
      KIND_RD_COILS:  fc = FC_RD_COILS;
      KIND_RD_HOLD:   fc = FC_RD_HOLD;
      KIND_RD_INPUT:  fc = FC_RD_INPUT;
      KIND_WR_SINGLE: fc = FC_WR_SINGLE;
      KIND_WR_MULTI:  fc = FC_WR_MULTI;
      default:        fc = FC_NONE;
    endcase
    return fc;
  endfunction

  // one byte through the reflected CRC, bit by bit
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/mbrc_if.sv -----
// Valid/ready channel interfaces for the response checker: byte words in, results out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mbrc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic        last_byte;
  logic [2:0]  request_kind;
  logic [7:0]  expected_slave;
  logic [15:0] expected_address;
  logic [15:0] expected_word;

  modport source (
    output valid, rx_byte, last_byte, request_kind, expected_slave,
           expected_address, expected_word,
    input  ready
  );
  modport sink (
    input  valid, rx_byte, last_byte, request_kind, expected_slave,
           expected_address, expected_word,
    output ready
  );
endinterface

interface mbrc_out_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [7:0] data_byte;
  logic [3:0] status;
  logic [7:0] exception_code;

  modport source (
    output valid, is_status, data_byte, status, exception_code,
    input  ready
  );
  modport sink (
    input  valid, is_status, data_byte, status, exception_code,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/mbrc_frame_eval.sv -----
// Per-frame state (byte count, CRC, header, echo words, request) and the checks.
// Depends on mbrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrc_frame_eval (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire mbrc_pkg::item_t item_i,
  output mbrc_pkg::result_t    res_o
);

  logic [mbrc_pkg::POS_W-1:0] pos_q, pos_d;
  logic [15:0]                crc_q, crc_d;
  logic [7:0]                 dly0_q, dly1_q;
  logic [7:0]                 hdr0_q, hdr1_q, hdr2_q;
  logic [7:0]                 hdr0_d, hdr1_d, hdr2_d;
  logic [15:0]                echo0_q, echo1_q, echo0_d, echo1_d;
  mbrc_pkg::req_t             req_q, req_cur;

  logic [mbrc_pkg::POS_W-1:0] size;
  logic [mbrc_pkg::POS_W-1:0] pay_idx;
  logic [mbrc_pkg::POS_W-1:0] want_len;
  logic [15:0]                crc_next, rx_crc;
  logic [7:0]                 fc;
  logic                       is_read, crc_ok;
  logic [16:0]                want_bc, coil_sum;
  mbrc_pkg::status_e          st;
  logic [7:0]                 exc;

  // request fields are sampled from the first word of a frame only
  assign req_cur  = (pos_q == '0) ? item_i.req : req_q;
  assign fc       = mbrc_pkg::fc_of_kind(req_cur.kind);
  assign is_read  = (req_cur.kind != mbrc_pkg::KIND_WR_SINGLE) &&
                    (req_cur.kind != mbrc_pkg::KIND_WR_MULTI);

  // CRC runs two bytes behind so the trailing CRC field is never fed
  assign crc_next = (pos_q >= 9'd2) ? mbrc_pkg::crc16_feed(crc_q, dly0_q) : crc_q;
  assign rx_crc   = {item_i.rx_byte, dly1_q};
  assign crc_ok   = (crc_next == rx_crc);

  assign hdr0_d = (pos_q == 9'd0) ? item_i.rx_byte : hdr0_q;
  assign hdr1_d = (pos_q == 9'd1) ? item_i.rx_byte : hdr1_q;
  assign hdr2_d = (pos_q == 9'd2) ? item_i.rx_byte : hdr2_q;

  always_comb begin
    echo0_d = echo0_q;
    echo1_d = echo1_q;
    case (pos_q)
      9'd2:    echo0_d = {item_i.rx_byte, 8'h00};
      9'd3:    echo0_d = echo0_q | {8'h00, item_i.rx_byte};
      9'd4:    echo1_d = {item_i.rx_byte, 8'h00};
      9'd5:    echo1_d = echo1_q | {8'h00, item_i.rx_byte};
      default: ;
    endcase
  end

  assign size     = (pos_q == mbrc_pkg::POS_MAX) ? mbrc_pkg::POS_MAX : pos_q + 9'd1;
  assign pay_idx  = pos_q - 9'd3;
  assign want_len = {1'b0, hdr2_d} + mbrc_pkg::MIN_FRAME;
  assign coil_sum = {1'b0, req_cur.qty_word} + 17'd7;
  assign want_bc  = (req_cur.kind == mbrc_pkg::KIND_RD_COILS) ? (coil_sum >> 3)
                                                              : {req_cur.qty_word, 1'b0};

  always_comb begin
    st  = mbrc_pkg::ST_OK;
    exc = 8'h00;
    if (is_read && req_cur.qty_word == 16'h0000) begin
      st = mbrc_pkg::ST_ZERO_QTY;
    end else if (size < mbrc_pkg::MIN_FRAME) begin
      st = mbrc_pkg::ST_SHORT;
    end else if (hdr0_d != req_cur.slave) begin
      st = mbrc_pkg::ST_SLAVE;
    end else if (hdr1_d == (fc | mbrc_pkg::FC_EXC_FLAG)) begin
      if (size != mbrc_pkg::MIN_FRAME) begin
        st = mbrc_pkg::ST_EXC_LEN;
      end else if (!crc_ok) begin
        st = mbrc_pkg::ST_EXC_CRC;
      end else begin
        st  = mbrc_pkg::ST_EXCEPTION;
        exc = hdr2_d;
      end
    end else if (hdr1_d != fc) begin
      st = mbrc_pkg::ST_FUNCTION;
    end else if (is_read) begin
      if (size != want_len) begin
        st = mbrc_pkg::ST_LENGTH;
      end else if (!crc_ok) begin
        st = mbrc_pkg::ST_CRC;
      end else if ({9'h000, hdr2_d} != want_bc) begin
        st = mbrc_pkg::ST_BYTE_COUNT;
      end
    end else begin
      if (size != mbrc_pkg::WRITE_FRAME) begin
        st = mbrc_pkg::ST_LENGTH;
      end else if (!crc_ok) begin
        st = mbrc_pkg::ST_CRC;
      end else if (echo0_d != req_cur.address) begin
        st = mbrc_pkg::ST_ADDRESS;
      end else if (echo1_d != req_cur.qty_word) begin
        st = mbrc_pkg::ST_VALUE;
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (item_i.last_byte) begin
      res_o.valid          = 1'b1;
      res_o.is_status      = 1'b1;
      res_o.status         = st;
      res_o.exception_code = exc;
    end else if (is_read && pos_q >= 9'd3 && pay_idx < {1'b0, hdr2_d}) begin
      res_o.valid     = 1'b1;
      res_o.data_byte = item_i.rx_byte;
    end
  end

  assign pos_d = item_i.last_byte ? '0 : size;
  assign crc_d = item_i.last_byte ? mbrc_pkg::CRC_INIT : crc_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= mbrc_pkg::CRC_INIT;
      dly0_q  <= '0;
      dly1_q  <= '0;
      hdr0_q  <= '0;
      hdr1_q  <= '0;
      hdr2_q  <= '0;
      echo0_q <= '0;
      echo1_q <= '0;
      req_q   <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      dly0_q  <= dly1_q;
      dly1_q  <= item_i.rx_byte;
      hdr0_q  <= hdr0_d;
      hdr1_q  <= hdr1_d;
      hdr2_q  <= hdr2_d;
      echo0_q <= echo0_d;
      echo1_q <= echo1_d;
      req_q   <= req_cur;
    end
  end

endmodule

`default_nettype wire

// ----- src/modbus_rtu_response_checker_core.sv -----
// Top level of the Modbus RTU response checker: input register, frame evaluation, result register.
// Depends on mbrc_pkg, mbrc_if and mbrc_frame_eval.
//
//   channel  dir  handshake    word
//   rx_i     in   valid/ready  one frame byte, last flag, request fields
//   tx_o     out  valid/ready  payload byte or final status
//
// One byte word per cycle while tx_o is not stalled; a result goes through the input and result registers.
// The byte-wide CRC update and the status checks sit between the input and result registers.
// Bytes that cause no result are absorbed without an output slot.
// Reset (rst_ni low) starts a new frame and empties both registers.
// A stalled tx_o holds its result; rx_i keeps accepting until the input register is also full.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_checker_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mbrc_in_if.sink    rx_i,
  mbrc_out_if.source tx_o
);

  logic              in_valid_q;
  mbrc_pkg::item_t   in_item_q;
  logic              out_valid_q, out_valid_d;
  mbrc_pkg::result_t out_q;
  mbrc_pkg::result_t res;
  logic              advance, step, in_fire;

  assign advance    = !out_valid_q || tx_o.ready;
  assign step       = in_valid_q && advance;
  assign rx_i.ready = !in_valid_q || advance;
  assign in_fire    = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q.rx_byte      <= rx_i.rx_byte;
      in_item_q.last_byte    <= rx_i.last_byte;
      in_item_q.req.kind     <= rx_i.request_kind;
      in_item_q.req.slave    <= rx_i.expected_slave;
      in_item_q.req.address  <= rx_i.expected_address;
      in_item_q.req.qty_word <= rx_i.expected_word;
    end
  end

  mbrc_frame_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .res_o  (res)
  );

  assign out_valid_d = advance ? (step && res.valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign tx_o.valid          = out_valid_q;
  assign tx_o.is_status      = out_q.is_status;
  assign tx_o.data_byte      = out_q.data_byte;
  assign tx_o.status         = out_q.status;
  assign tx_o.exception_code = out_q.exception_code;

endmodule

`default_nettype wire

// ----- verif/mbrc_frame_monitor.sv -----
// Watches both channels of the Modbus RTU response checker and predicts every result word.
// Depends on mbrc_pkg and mbrc_if; the failure and outstanding counts go to the testbench top.
`timescale 1ns / 1ps
`default_nettype none

module mbrc_frame_monitor
  import mbrc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mbrc_in_if        rx_mon_i,
  mbrc_out_if       tx_mon_i,
  output int        fail_count_o,
  output int        awaited_count_o
);

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    status_e    status;
    logic [7:0] exc_code;
  } outcome_t;

  outcome_t    awaited_q[$];
  outcome_t    head;
  int          mismatches;

  // predicted frame state
  logic [8:0]  frame_pos;
  logic [15:0] crc_run;
  logic [7:0]  lag_bytes[2];
  logic [7:0]  header_bytes[3];
  logic [15:0] echo_regs[2];
  req_t        frame_req;

  function automatic logic [7:0] function_code(input logic [2:0] kind);
    case (kind)
      KIND_RD_COILS:  return FC_RD_COILS;
      KIND_RD_HOLD:   return FC_RD_HOLD;
      KIND_RD_INPUT:  return FC_RD_INPUT;
      KIND_WR_SINGLE: return FC_WR_SINGLE;
      KIND_WR_MULTI:  return FC_WR_MULTI;
      default:        return FC_NONE;
    endcase
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ CRC_POLY) : {1'b0, c[15:1]};
    return c;
  endfunction

  function automatic void queue_outcome(input outcome_t o);
    awaited_q = {awaited_q, o};
  endfunction

  task automatic predict_word(input logic [7:0] b, input logic last, input req_t req_in);
    logic [8:0]  pos;
    logic [8:0]  size;
    logic [7:0]  fc;
    logic [7:0]  prev;
    logic        is_read;
    logic [15:0] rx_crc;
    int unsigned qty;
    int unsigned bc;
    int unsigned want;
    status_e     st;
    logic [7:0]  exc;
    pos = frame_pos;
    if (pos == 9'd0) frame_req = req_in;
    fc = function_code(frame_req.kind);
    is_read = (frame_req.kind != KIND_WR_SINGLE) && (frame_req.kind != KIND_WR_MULTI);
    // CRC runs two bytes behind, so the trailing CRC pair is never folded in
    if (pos >= 9'd2) crc_run = crc_step(crc_run, lag_bytes[0]);
    prev = lag_bytes[1];
    lag_bytes[0] = lag_bytes[1];
    lag_bytes[1] = b;
    if (pos < 9'd3) header_bytes[pos] = b;
    case (pos)
      9'd2: echo_regs[0] = {b, 8'h00};
      9'd3: echo_regs[0] = echo_regs[0] | {8'h00, b};
      9'd4: echo_regs[1] = {b, 8'h00};
      9'd5: echo_regs[1] = echo_regs[1] | {8'h00, b};
      default: ;
    endcase
    size = (pos == POS_MAX) ? POS_MAX : pos + 9'd1;
    if (!last) begin
      frame_pos = size;
      if (is_read && pos >= 9'd3 && (pos - 9'd3) < {1'b0, header_bytes[2]})
        queue_outcome(outcome_t'{1'b0, b, ST_OK, 8'h00});
    end else begin
      rx_crc = {b, prev};
      qty = frame_req.qty_word;
      bc = header_bytes[2];
      st = ST_OK;
      exc = 8'h00;
      if (is_read && qty == 0) st = ST_ZERO_QTY;
      else if (size < MIN_FRAME) st = ST_SHORT;
      else if (header_bytes[0] != frame_req.slave) st = ST_SLAVE;
      else if (header_bytes[1] == (fc | FC_EXC_FLAG)) begin
        if (size != MIN_FRAME) st = ST_EXC_LEN;
        else if (crc_run != rx_crc) st = ST_EXC_CRC;
        else begin
          st = ST_EXCEPTION;
          exc = header_bytes[2];
        end
      end else if (header_bytes[1] != fc) st = ST_FUNCTION;
      else if (is_read) begin
        want = (frame_req.kind == KIND_RD_COILS) ? (qty + 7) / 8 : qty * 2;
        if (int'(size) != bc + 5) st = ST_LENGTH;
        else if (crc_run != rx_crc) st = ST_CRC;
        else if (bc != want) st = ST_BYTE_COUNT;
      end else begin
        if (size != WRITE_FRAME) st = ST_LENGTH;
        else if (crc_run != rx_crc) st = ST_CRC;
        else if (echo_regs[0] != frame_req.address) st = ST_ADDRESS;
        else if (echo_regs[1] != frame_req.qty_word) st = ST_VALUE;
      end
      frame_pos = '0;
      crc_run = CRC_INIT;
      queue_outcome(outcome_t'{1'b1, 8'h00, st, exc});
    end
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos = '0;
      crc_run = CRC_INIT;
      lag_bytes = '{8'h00, 8'h00};
      header_bytes = '{8'h00, 8'h00, 8'h00};
      echo_regs = '{16'h0000, 16'h0000};
      frame_req = '0;
      awaited_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      awaited_count_o <= 0;
    end else begin
      if (rx_mon_i.valid && rx_mon_i.ready)
        predict_word(rx_mon_i.rx_byte, rx_mon_i.last_byte,
                     {rx_mon_i.request_kind, rx_mon_i.expected_slave,
                      rx_mon_i.expected_address, rx_mon_i.expected_word});
      if (tx_mon_i.valid && tx_mon_i.ready) begin
        if (awaited_q.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, actual status %0d data %0d",
                   $time, tx_mon_i.status, tx_mon_i.data_byte);
        end else begin
          head = awaited_q.pop_front();
          check_field("is_status", head.is_status, tx_mon_i.is_status);
          check_field("data_byte", head.data_byte, tx_mon_i.data_byte);
          check_field("status", head.status, tx_mon_i.status);
          check_field("exception_code", head.exc_code, tx_mon_i.exception_code);
        end
      end
      fail_count_o <= mismatches;
      awaited_count_o <= awaited_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_modbus_rtu_response_checker_core.sv -----
// Testbench top for the Modbus RTU response checker: clock, reset, frame stimulus, output stalls.
// Depends on mbrc_pkg, mbrc_if, the core and mbrc_frame_monitor, which does all checking.
`timescale 1ns / 1ps
`default_nettype none

module tb_modbus_rtu_response_checker_core;
  import mbrc_pkg::*;

  localparam int unsigned RANDOM_WORDS = 140;
  localparam int unsigned HOLD_AFTER   = 60;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned LONG_FRAME   = 520;
  localparam logic [2:0]  KIND_UNUSED  = 3'd7;

  typedef enum int unsigned {RDY_ALWAYS, RDY_HALF, RDY_SPARSE} ready_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int          fail_count;
  int          awaited_count;
  int unsigned cycle_count = 0;
  int unsigned sent_words = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  ready_mode_e stall_mode = RDY_ALWAYS;
  logic        hold_off_req = 1'b0;
  logic        hold_done = 1'b0;
  logic [7:0]  frame_q[$];
  req_t        frame_req;

  mbrc_in_if  rx_if ();
  mbrc_out_if tx_if ();

  modbus_rtu_response_checker_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .tx_o   (tx_if)
  );

  mbrc_frame_monitor u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_mon_i        (rx_if),
    .tx_mon_i        (tx_if),
    .fail_count_o    (fail_count),
    .awaited_count_o (awaited_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: changing stall patterns, plus one long hold-off mid-run
  initial begin
    tx_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        tx_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (stall_left == 0) begin
        stall_mode = ready_mode_e'($urandom_range(0, 2));
        stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      case (stall_mode)
        RDY_ALWAYS: tx_if.ready <= 1'b1;
        RDY_HALF:   tx_if.ready <= 1'($urandom_range(0, 1));
        default:    tx_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic req_t any_request();
    req_t r;
    r.kind = 3'($urandom);
    r.slave = 8'($urandom);
    r.address = 16'($urandom);
    r.qty_word = 16'($urandom);
    return r;
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    frame_q = {frame_q, b};
  endfunction

  function automatic void seal_frame();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_q[i]) c = crc16_feed(c, frame_q[i]);
    append_byte(c[7:0]);
    append_byte(c[15:8]);
  endfunction

  function automatic void build_read(input logic [7:0] sl, input logic [7:0] fc,
                                     input logic [7:0] bc);
    frame_q.delete();
    append_byte(sl);
    append_byte(fc);
    append_byte(bc);
    repeat (bc) append_byte(8'($urandom));
    seal_frame();
  endfunction

  function automatic void build_write(input logic [7:0] sl, input logic [7:0] fc,
                                      input logic [15:0] ad, input logic [15:0] wd);
    frame_q.delete();
    append_byte(sl);
    append_byte(fc);
    append_byte(ad[15:8]);
    append_byte(ad[7:0]);
    append_byte(wd[15:8]);
    append_byte(wd[7:0]);
    seal_frame();
  endfunction

  function automatic void build_exception(input logic [7:0] sl, input logic [7:0] fc,
                                          input logic [7:0] code);
    frame_q.delete();
    append_byte(sl);
    append_byte(fc);
    append_byte(code);
    seal_frame();
  endfunction

  // mostly well-formed responses, some with one field off under a good CRC, some damaged
  function automatic req_t random_frame();
    req_t        r;
    logic [7:0]  sl;
    logic [7:0]  fc;
    logic [7:0]  bc;
    logic [15:0] ad;
    logic [15:0] wd;
    int unsigned want;
    int unsigned idx;
    r = any_request();
    r.kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    case ($urandom_range(0, 19))
      0:       r.qty_word = 16'h0000;
      1, 2:    r.qty_word = 16'($urandom);
      default: r.qty_word = (r.kind == KIND_RD_COILS) ? 16'($urandom_range(1, 160)) :
                                                        16'($urandom_range(1, 12));
    endcase
    want = (r.kind == KIND_RD_COILS) ? (int'(r.qty_word) + 7) / 8 : int'(r.qty_word) * 2;
    bc = (want > 255) ? 8'($urandom_range(0, 20)) : 8'(want);
    sl = r.slave;
    fc = fc_of_kind(r.kind);
    ad = r.address;
    wd = r.qty_word;
    case ($urandom_range(0, 15))
      0:       sl ^= 8'(1 << $urandom_range(0, 7));
      1:       fc = 8'($urandom);
      2:       bc += 8'($urandom_range(1, 3));
      3:       ad ^= 16'(1 << $urandom_range(0, 15));
      4:       wd ^= 16'(1 << $urandom_range(0, 15));
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) build_exception(sl, fc | FC_EXC_FLAG, 8'($urandom));
    else if (r.kind == KIND_WR_SINGLE || r.kind == KIND_WR_MULTI) build_write(sl, fc, ad, wd);
    else build_read(sl, fc, bc);
    case ($urandom_range(0, 11))
      0: begin
        idx = $urandom_range(0, frame_q.size() - 1);
        frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(0, 7));
      end
      1: if (frame_q.size() > 1) frame_q.delete($urandom_range(0, frame_q.size() - 1));
      2: frame_q.insert($urandom_range(0, frame_q.size()), 8'($urandom));
      3: begin
        frame_q.delete();
        repeat ($urandom_range(1, 10)) append_byte(8'($urandom));
      end
      default: ;
    endcase
    return r;
  endfunction

  // sender bursts: random-length runs of words, random gaps in between
  task automatic send_word(input logic [7:0] b, input logic last, input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    rx_if.last_byte <= last;
    rx_if.request_kind <= r.kind;
    rx_if.expected_slave <= r.slave;
    rx_if.expected_address <= r.address;
    rx_if.expected_word <= r.qty_word;
    do @(posedge clk_i); while (!rx_if.ready);
    sent_words++;
  endtask

  // request fields only count on the first byte; later bytes carry junk there
  task automatic send_frame(input req_t r);
    int unsigned n;
    n = frame_q.size();
    for (int unsigned i = 0; i < n; i++)
      send_word(frame_q[i], i == n - 1, (i == 0) ? r : any_request());
  endtask

  initial begin
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    rx_if.last_byte <= 1'b0;
    rx_if.request_kind <= KIND_RD_COILS;
    rx_if.expected_slave <= 8'h00;
    rx_if.expected_address <= 16'h0000;
    rx_if.expected_word <= 16'h0000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // good coil read
    build_read(8'hFF, FC_RD_COILS, 8'd2);
    send_frame(req_t'{KIND_RD_COILS, 8'hFF, 16'hFFFF, 16'd16});
    // zero quantity wins even over a one-byte frame
    frame_q = '{8'h00};
    send_frame(req_t'{KIND_RD_HOLD, 8'h00, 16'h0000, 16'h0000});
    // too short
    frame_q = '{8'hFF, FC_RD_INPUT};
    send_frame(req_t'{KIND_RD_INPUT, 8'hFF, 16'h0000, 16'hFFFF});
    // exception response with all-ones code
    build_exception(8'h00, FC_RD_INPUT | FC_EXC_FLAG, 8'hFF);
    send_frame(req_t'{KIND_RD_INPUT, 8'h00, 16'h0000, 16'd1});
    // good write single echo
    build_write(8'hA5, FC_WR_SINGLE, 16'hFFFF, 16'h0000);
    send_frame(req_t'{KIND_WR_SINGLE, 8'hA5, 16'hFFFF, 16'h0000});
    // write multiple with a wrong quantity echo
    build_write(8'h5A, FC_WR_MULTI, 16'h0000, 16'hFFFE);
    send_frame(req_t'{KIND_WR_MULTI, 8'h5A, 16'h0000, 16'hFFFF});
    // unknown kind reads with function code zero
    build_read(8'h01, FC_NONE, 8'd0);
    send_frame(req_t'{KIND_UNUSED, 8'h01, 16'h0000, 16'd1});

    // over-long read: byte counter saturates, full byte count of payload passes through
    frame_q.delete();
    append_byte(8'h11);
    append_byte(FC_RD_HOLD);
    append_byte(8'hFF);
    while (frame_q.size() < LONG_FRAME) append_byte(8'($urandom));
    send_frame(req_t'{KIND_RD_HOLD, 8'h11, 16'h0000, 16'd1});

    while (sent_words < LONG_FRAME + 40 + RANDOM_WORDS) begin
      if (sent_words >= LONG_FRAME + HOLD_AFTER) hold_off_req <= 1'b1;
      frame_req = random_frame();
      send_frame(frame_req);
    end
    rx_if.valid <= 1'b0;

    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
src/mbrc_pkg.sv
src/mbrc_if.sv
src/mbrc_frame_eval.sv
src/modbus_rtu_response_checker_core.sv
verif/mbrc_frame_monitor.sv
verif/tb_modbus_rtu_response_checker_core.sv
